// ===== hdl/msic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msic_pkg;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_ADDR  = 2'd1,
		FAULT_INSTR = 2'd2
	} fault_t;

	localparam logic [2:0] CAT_CTRL = 3'b001;
	localparam logic [2:0] CAT_REG  = 3'b010;
	localparam logic [2:0] CAT_IMM  = 3'b100;

	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_J     = 3'd1;
	localparam logic [2:0] OP_BEQ   = 3'd2;
	localparam logic [2:0] OP_BNE   = 3'd3;
	localparam logic [2:0] OP_BGTZ  = 3'd4;
	localparam logic [2:0] OP_SW    = 3'd5;
	localparam logic [2:0] OP_LW    = 3'd6;
	localparam logic [2:0] OP_BREAK = 3'd7;

	// Register category opcodes
	localparam logic [2:0] R_XOR  = 3'd0;
	localparam logic [2:0] R_MUL  = 3'd1;
	localparam logic [2:0] R_ADD  = 3'd2;
	localparam logic [2:0] R_SUB  = 3'd3;
	localparam logic [2:0] R_AND  = 3'd4;
	localparam logic [2:0] R_OR   = 3'd5;
	localparam logic [2:0] R_ADDU = 3'd6;
	localparam logic [2:0] R_SUBU = 3'd7;

	// Immediate category opcodes
	localparam logic [2:0] I_ORI  = 3'd0;
	localparam logic [2:0] I_XORI = 3'd1;
	localparam logic [2:0] I_ADDI = 3'd2;
	localparam logic [2:0] I_SUBI = 3'd3;
	localparam logic [2:0] I_ANDI = 3'd4;
	localparam logic [2:0] I_SRL  = 3'd5;
	localparam logic [2:0] I_SRA  = 3'd6;
	localparam logic [2:0] I_SLL  = 3'd7;

	localparam logic [31:0] JUMP_MASK = 32'hF000_0000;

	// Controller to datapath commands
	typedef struct packed {
		logic load_wr;   // write loaded word at load pointer
		logic fetch;     // read instruction at pc
		logic exec;      // decode, execute, start data access
		logic finish;    // commit and emit result
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic stopped;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/msic_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/msic_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msic_ctrl import msic_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    kind,
	input  wire dp_sts_t sts,
	output logic         busy,
	output dp_cmd_t      cmd
);
	typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_DONE} state_t;
	state_t state_q;

	wire logic accept = start && !busy;

	// Sequence fetch, execute, finish; loads finish in the accept cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (accept && kind) state_q <= S_FETCH;
				S_FETCH: state_q <= S_EXEC;
				S_EXEC:  state_q <= S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.load_wr = accept && !kind;
	assign cmd.fetch   = (state_q == S_FETCH);
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.finish  = (state_q == S_DONE);

	a_exec_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> cmd.exec) else $error("exec must follow fetch");
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> cmd.finish) else $error("finish must follow exec");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fetch, cmd.exec, cmd.finish, cmd.load_wr}))
		else $error("commands overlap");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sts.stopped |=> sts.stopped) else $error("stop cleared");
endmodule
`default_nettype wire

// ===== hdl/msic_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msic_dp import msic_pkg::*; #(
	parameter int MEM_WORDS    = 1024,
	parameter int BASE_ADDRESS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	input  wire logic [31:0] word,
	output dp_sts_t          sts,
	output logic             done,
	output logic [31:0]      exec_address,
	output logic             reg_written,
	output logic [4:0]       reg_number,
	output logic [31:0]      reg_value,
	output logic             mem_written,
	output logic [31:0]      mem_address,
	output logic [31:0]      mem_value,
	output logic             halted_flag,
	output logic [1:0]       fault_code
);
	localparam int AW = $clog2(MEM_WORDS);
	localparam int LW = $clog2(MEM_WORDS + 1);

	logic [31:0] pc_q;
	logic [LW-1:0] lptr_q;
	logic stopped_q;
	logic [31:0] rf_q [32];

	// Address check: in range and word aligned from base
	function automatic logic addr_ok(input logic [31:0] a);
		logic [31:0] off;
		off = a - 32'(BASE_ADDRESS);
		return (a >= 32'(BASE_ADDRESS)) && (off[1:0] == 2'b00)
			&& ({2'b00, off[31:2]} < 32'(MEM_WORDS));
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Memory port selection
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	logic [31:0] pc_off, dat_off, dat_addr;
	assign pc_off  = pc_q - 32'(BASE_ADDRESS);

	logic [31:0] ins;
	assign ins = ram_rdata;
	wire logic [2:0]  cat = ins[31:29];
	wire logic [2:0]  op  = ins[28:26];
	wire logic [4:0]  f1  = ins[25:21];
	wire logic [4:0]  f2  = ins[20:16];
	wire logic [4:0]  f3  = ins[15:11];
	wire logic [15:0] imm = ins[15:0];
	wire logic [31:0] a   = rf_q[f1];
	wire logic [31:0] b   = rf_q[f2];
	wire logic [31:0] c   = rf_q[f3];

	assign dat_addr = a + sext16(imm);
	assign dat_off  = dat_addr - 32'(BASE_ADDRESS);

	// Execute stage results, held for the finish cycle
	logic        rw_q, mw_q, lw_q, halt_q, fetch_ok_q;
	logic [4:0]  rnum_q;
	logic [31:0] res_q, maddr_q, mval_q, next_q;
	fault_t      fault_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lptr_q[AW-1:0];
		ram_wdata = word;
		ram_raddr = pc_off[AW+1:2];
		if (cmd.load_wr && (lptr_q < LW'(MEM_WORDS))) begin
			ram_we = 1'b1;
		end
		if (cmd.exec) begin
			ram_raddr = dat_off[AW+1:2];
			// Store only for a valid fetch while running
			if (fetch_ok_q && !stopped_q && cat == CAT_CTRL && op == OP_SW
				&& addr_ok(dat_addr)) begin
				ram_we    = 1'b1;
				ram_waddr = dat_off[AW+1:2];
				ram_wdata = b;
			end
		end
	end

	msic_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic [31:0] mul_res;
	assign mul_res = b * c;

	logic        rw_d, mw_d, lw_d, halt_d;
	logic [4:0]  rnum_d;
	logic [31:0] res_d, next_d, tgt;
	fault_t      fault_d;

	// Decode and execute
	always_comb begin
		rw_d = 1'b0; mw_d = 1'b0; lw_d = 1'b0; halt_d = 1'b0;
		rnum_d = '0; res_d = '0; fault_d = FAULT_NONE;
		next_d = pc_q + 32'd4;
		tgt = pc_q + 32'd4 + (sext16(imm) << 2);
		if (!fetch_ok_q) begin
			fault_d = FAULT_ADDR;
		end else if (cat == CAT_CTRL) begin
			unique case (op)
				OP_NOP: ;
				OP_J: next_d = (next_d & JUMP_MASK) | {4'b0000, ins[25:0], 2'b00};
				OP_BEQ: if (a == b) next_d = tgt;
				OP_BNE: if (a != b) next_d = tgt;
				OP_BGTZ: if (a != 32'd0 && !a[31]) next_d = tgt;
				OP_SW, OP_LW: begin
					if (!addr_ok(dat_addr)) begin
						fault_d = FAULT_ADDR;
					end else if (op == OP_SW) begin
						mw_d = 1'b1;
					end else begin
						lw_d = 1'b1; rw_d = 1'b1; rnum_d = f2;
					end
				end
				default: begin
					halt_d = 1'b1; next_d = pc_q;
				end
			endcase
		end else if (cat == CAT_REG) begin
			rw_d = 1'b1; rnum_d = f1;
			unique case (op)
				R_XOR: res_d = b ^ c;
				R_MUL: res_d = mul_res;
				R_ADD, R_ADDU: res_d = b + c;
				R_SUB, R_SUBU: res_d = b - c;
				R_AND: res_d = b & c;
				default: res_d = b | c;
			endcase
		end else if (cat == CAT_IMM) begin
			rw_d = 1'b1; rnum_d = f1;
			unique case (op)
				I_ORI: res_d = b | {16'd0, imm};
				I_XORI: res_d = b ^ {16'd0, imm};
				I_ADDI: res_d = b + sext16(imm);
				I_SUBI: res_d = b - sext16(imm);
				I_ANDI: res_d = b & {16'd0, imm};
				I_SRL: res_d = b >> ins[4:0];
				I_SRA: res_d = 32'($signed(b) >>> ins[4:0]);
				default: res_d = b << ins[4:0];
			endcase
		end else begin
			fault_d = FAULT_INSTR;
		end
	end

	// Hold fetch validity and execute results
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			fetch_ok_q <= addr_ok(pc_q);
		end
		if (cmd.exec) begin
			rw_q <= rw_d && !stopped_q; mw_q <= mw_d && !stopped_q;
			lw_q <= lw_d; halt_q <= halt_d;
			rnum_q <= rnum_d; res_q <= res_d; next_q <= next_d;
			fault_q <= fault_d; maddr_q <= dat_addr; mval_q <= b;
		end
	end

	wire logic [31:0] wb_val = lw_q ? ram_rdata : res_q;

	// Commit architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 32'(BASE_ADDRESS);
			lptr_q <= '0;
			stopped_q <= 1'b0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			if (cmd.load_wr && (lptr_q < LW'(MEM_WORDS))) lptr_q <= lptr_q + 1'b1;
			if (cmd.finish && !stopped_q) begin
				pc_q <= next_q;
				if (halt_q) stopped_q <= 1'b1;
				if (rw_q) rf_q[rnum_q] <= wb_val;
			end
		end
	end

	// Result outputs
	assign done         = cmd.finish;
	assign exec_address = pc_q;
	assign reg_written  = rw_q && !stopped_q;
	assign reg_number   = reg_written ? rnum_q : 5'd0;
	assign reg_value    = reg_written ? wb_val : 32'd0;
	assign mem_written  = mw_q && !stopped_q;
	assign mem_address  = mem_written ? maddr_q : 32'd0;
	assign mem_value    = mem_written ? mval_q : 32'd0;
	assign halted_flag  = stopped_q || halt_q;
	assign fault_code   = stopped_q ? FAULT_NONE : fault_q;
	assign sts.stopped  = stopped_q;

	a_halt_keeps_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && stopped_q) |=> $stable(pc_q)) else $error("pc moved while halted");
	a_no_write_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && fault_code != FAULT_NONE) |-> (!reg_written && !mem_written))
		else $error("write on fault");
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(reg_written && mem_written)) else $error("two writes");
endmodule
`default_nettype wire

// ===== hdl/mips_subset_instruction_core_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load transaction: taken in the accept cycle, busy stays low, no result.
// Execute transaction: busy through the fetch, execute and finish states;
// the result strobe is high in the finish state. No new execute is taken
// until the last finishes; one load per cycle while idle; no output stall.
// Reset: pc to base address, registers and load pointer cleared, not halted.
module mips_subset_instruction_core_unit import msic_pkg::*; #(
	parameter int MEM_WORDS    = 1024,
	parameter int BASE_ADDRESS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [31:0] word,
	output logic             done,
	output logic [31:0]      exec_address,
	output logic             reg_written,
	output logic [4:0]       reg_number,
	output logic [31:0]      reg_value,
	output logic             mem_written,
	output logic [31:0]      mem_address,
	output logic [31:0]      mem_value,
	output logic             halted_flag,
	output logic [1:0]       fault_code
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	msic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	msic_dp #(.MEM_WORDS(MEM_WORDS), .BASE_ADDRESS(BASE_ADDRESS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .word(word), .sts(sts),
		.done(done), .exec_address(exec_address), .reg_written(reg_written),
		.reg_number(reg_number), .reg_value(reg_value),
		.mem_written(mem_written), .mem_address(mem_address),
		.mem_value(mem_value), .halted_flag(halted_flag),
		.fault_code(fault_code)
	);
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import msic_pkg::*;

	localparam int          CORE_WORDS = 1024;
	localparam logic [31:0] LOAD_BASE  = 32'd64;
	localparam int          DATA_WORDS = 128;   // words 0..127 hold boot code and data
	localparam int          CODE_LIMIT = 990;   // stop the random program before the end
	localparam int          ITEM_BUDGET = 740;  // cap on all queued transactions while the random program grows

	localparam logic [15:0] DATA_MASK = 16'h01F0;  // pointer into the data words
	localparam logic [15:0] DATA_OFS  = 16'd76;
	localparam logic [15:0] FAR_OFS   = 16'h7FFC;  // lands past the memory
	localparam logic [15:0] ODD_OFS   = 16'd78;    // misaligned

	typedef struct packed {
		logic [31:0] exec_address;
		logic        reg_written;
		logic [4:0]  reg_number;
		logic [31:0] reg_value;
		logic        mem_written;
		logic [31:0] mem_address;
		logic [31:0] mem_value;
		logic        halted_flag;
		fault_t      fault_code;
	} step_result_t;

	typedef struct {
		bit           kind;
		logic [31:0]  word;
		bit           drain;
		step_result_t outcome;
	} core_txn_t;

	logic        clk, arst_n, start, kind, done, busy;
	logic [31:0] word;
	logic [31:0] exec_address, reg_value, mem_address, mem_value;
	logic        reg_written, mem_written, halted_flag;
	logic [4:0]  reg_number;
	logic [1:0]  fault_code;

	// Shadow copy of the core state
	logic [31:0] mem_image [CORE_WORDS];
	bit          word_seen [CORE_WORDS];
	logic [31:0] gpr [32];
	logic [31:0] pc_model;
	int unsigned load_ptr;
	bit          core_halted;
	bit          pair_armed;
	logic [4:0]  pair_reg;

	core_txn_t    txn_q [$];
	step_result_t result_q [$];
	core_txn_t    in_flight;
	bit           handed;
	int           idle_left;
	bit           burst_mode;
	int           burst_left;
	int           mismatches;
	int           step_count;

	mips_subset_instruction_core_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind), .word(word),
		.done(done), .exec_address(exec_address), .reg_written(reg_written),
		.reg_number(reg_number), .reg_value(reg_value), .mem_written(mem_written),
		.mem_address(mem_address), .mem_value(mem_value), .halted_flag(halted_flag),
		.fault_code(fault_code)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] sext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Map a byte address to a word index; false when out of range or misaligned
	function automatic bit word_index(input logic [31:0] a, output int unsigned i);
		logic [31:0] off;
		i = 0;
		if (a < LOAD_BASE) return 0;
		off = a - LOAD_BASE;
		if (off[1:0] != 2'b00) return 0;
		if ((off >> 2) >= CORE_WORDS) return 0;
		i = off >> 2;
		return 1;
	endfunction

	// Execute one instruction on the shadow state and return what it reports
	function automatic step_result_t run_instruction();
		step_result_t r;
		logic [31:0] ins, a, b, c, res, nxt, tgt, addr;
		logic [2:0] cat, op;
		logic [4:0] f1, f2, f3, sh;
		logic [15:0] imm;
		int unsigned idx;
		bit rw;
		r = '0;
		r.exec_address = pc_model;
		if (core_halted) begin
			r.halted_flag = 1'b1;
			return r;
		end
		nxt = pc_model + 32'd4;
		rw = 0;
		res = '0;
		if (!word_index(pc_model, idx)) begin
			r.fault_code = FAULT_ADDR;
		end else begin
			ins = mem_image[idx];
			cat = ins[31:29];
			op = ins[28:26];
			f1 = ins[25:21];
			f2 = ins[20:16];
			f3 = ins[15:11];
			imm = ins[15:0];
			sh = ins[4:0];
			a = gpr[f1];
			b = gpr[f2];
			c = gpr[f3];
			if (cat == CAT_CTRL) begin
				tgt = nxt + (sext16(imm) << 2);
				case (op)
					OP_NOP: ;
					OP_J: nxt = (nxt & JUMP_MASK) | {4'b0, ins[25:0], 2'b00};
					OP_BEQ: if (a == b) nxt = tgt;
					OP_BNE: if (a != b) nxt = tgt;
					OP_BGTZ: if ($signed(a) > 0) nxt = tgt;
					OP_SW, OP_LW: begin
						addr = a + sext16(imm);
						if (!word_index(addr, idx)) begin
							r.fault_code = FAULT_ADDR;
						end else if (op == OP_SW) begin
							mem_image[idx] = b;
							word_seen[idx] = 1;
							r.mem_written = 1'b1;
							r.mem_address = addr;
							r.mem_value = b;
						end else begin
							res = mem_image[idx];
							rw = 1;
							r.reg_number = f2;
						end
					end
					default: begin
						core_halted = 1;
						nxt = pc_model;
					end
				endcase
			end else if (cat == CAT_REG) begin
				case (op)
					R_XOR: res = b ^ c;
					R_MUL: res = b * c;
					R_ADD, R_ADDU: res = b + c;
					R_SUB, R_SUBU: res = b - c;
					R_AND: res = b & c;
					default: res = b | c;
				endcase
				rw = 1;
				r.reg_number = f1;
			end else if (cat == CAT_IMM) begin
				case (op)
					I_ORI: res = b | {16'b0, imm};
					I_XORI: res = b ^ {16'b0, imm};
					I_ADDI: res = b + sext16(imm);
					I_SUBI: res = b - sext16(imm);
					I_ANDI: res = b & {16'b0, imm};
					I_SRL: res = b >> sh;
					I_SRA: res = $signed(b) >>> sh;
					default: res = b << sh;
				endcase
				rw = 1;
				r.reg_number = f1;
			end else begin
				r.fault_code = FAULT_INSTR;
			end
		end
		if (rw) begin
			gpr[r.reg_number] = res;
			r.reg_written = 1'b1;
			r.reg_value = res;
		end
		pc_model = nxt;
		r.halted_flag = core_halted;
		return r;
	endfunction

	function automatic void queue_load(logic [31:0] w);
		core_txn_t t;
		if (load_ptr < CORE_WORDS) begin
			mem_image[load_ptr] = w;
			word_seen[load_ptr] = 1;
			load_ptr++;
		end
		t.kind = 1'b0;
		t.word = w;
		t.drain = 0;
		t.outcome = '0;
		txn_q = {txn_q, t};
	endfunction

	function automatic void queue_step(bit drain);
		core_txn_t t;
		t.kind = 1'b1;
		t.word = $urandom;
		t.drain = drain;
		t.outcome = run_instruction();
		txn_q = {txn_q, t};
		step_count++;
	endfunction

	// Next program word for slot k; code only ever flows forward
	function automatic logic [31:0] make_code_word(int unsigned k);
		int unsigned pick, tgt;
		logic [2:0] cat;
		logic [2:0] mem_op;
		mem_op = ($urandom_range(0, 1) == 0) ? OP_SW : OP_LW;
		if (pair_armed) begin
			pair_armed = 0;
			return {CAT_CTRL, mem_op, pair_reg, 5'($urandom), DATA_OFS};
		end
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return {CAT_REG, 3'($urandom), 26'($urandom)};
		if (pick < 50)
			return {CAT_IMM, 3'($urandom), 10'($urandom),
				($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom)};
		if (pick < 56)
			return {CAT_CTRL, OP_NOP, 26'($urandom)};
		if (pick < 68)
			return {CAT_CTRL, 3'($urandom_range(OP_BEQ, OP_BGTZ)), 10'($urandom),
				16'($urandom_range(0, 7))};
		if (pick < 76) begin
			tgt = k + $urandom_range(1, 4);
			return {CAT_CTRL, OP_J, 26'((LOAD_BASE >> 2) + tgt)};
		end
		if (pick < 88) begin
			pair_armed = 1;
			pair_reg = 5'($urandom);
			return {CAT_IMM, I_ANDI, pair_reg, 5'($urandom), DATA_MASK};
		end
		if (pick < 94)
			return {CAT_CTRL, mem_op, pair_reg, 5'($urandom),
				($urandom_range(0, 1) == 0) ? FAR_OFS : ODD_OFS};
		do cat = 3'($urandom); while (cat == CAT_CTRL || cat == CAT_REG || cat == CAT_IMM);
		return {cat, 29'($urandom)};
	endfunction

	// Load ahead so that neither the fetch nor a load word reads an unwritten word
	function automatic void fill_ahead();
		int unsigned idx, didx;
		logic [31:0] ins, addr;
		forever begin
			if (!word_index(pc_model, idx) || core_halted) return;
			if (idx >= load_ptr) begin
				queue_load(make_code_word(load_ptr));
				continue;
			end
			ins = mem_image[idx];
			if (ins[31:29] == CAT_CTRL && ins[28:26] == OP_LW) begin
				addr = gpr[ins[25:21]] + sext16(ins[15:0]);
				if (word_index(addr, didx) && !word_seen[didx]) begin
					queue_load(make_code_word(load_ptr));
					continue;
				end
			end
			return;
		end
	endfunction

	function automatic void build_program();
		int unsigned idx;
		int cap;
		logic [31:0] edge_words [5];
		edge_words = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
		foreach (gpr[i]) gpr[i] = '0;
		pc_model = LOAD_BASE;
		load_ptr = 0;
		core_halted = 0;
		pair_armed = 0;
		pair_reg = '0;
		// Boot: toggle r1, branch below the memory on the first pass, then jump to code
		queue_load({CAT_IMM, I_XORI, 5'd1, 5'd1, 16'd1});
		queue_load({CAT_CTRL, OP_BGTZ, 5'd1, 5'd0, -16'sd12});
		queue_load({CAT_CTRL, OP_J, 26'((LOAD_BASE >> 2) + DATA_WORDS)});
		for (int i = 3; i < DATA_WORDS; i++)
			queue_load(i < 8 ? edge_words[i - 3] : $urandom);
		// Walk up through the fetch faults and back into the boot code
		repeat (15) queue_step(0);
		// Random program, generated as execution reaches it
		while (step_count < 470 && load_ptr < CODE_LIMIT && txn_q.size() < ITEM_BUDGET) begin
			if ($urandom_range(0, 4) == 0) queue_load(make_code_word(load_ptr));
			fill_ahead();
			queue_step(step_count == 200);
		end
		// Run up to the unwritten end of the program and halt there
		cap = 0;
		while (!core_halted && cap < 3000) begin
			if (word_index(pc_model, idx) && idx == load_ptr) begin
				queue_load({CAT_CTRL, OP_BREAK, 26'($urandom)});
				queue_step(0);
			end else begin
				fill_ahead();
				queue_step(0);
			end
			cap++;
		end
		repeat (3) queue_step(0);
		// Loads after halt still write
		repeat (40) queue_load($urandom);
		repeat (2) queue_step(0);
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		if (burst_left == 0) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(20, 120);
		end
		burst_left--;
		if (burst_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Driver: present the next transaction, hold it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !handed) begin
		end else if (idle_left > 0) begin
			start <= 1'b0;
			idle_left <= idle_left - 1;
		end else if (txn_q.size() == 0) begin
			start <= 1'b0;
		end else if (txn_q[0].drain && (result_q.size() != 0 || busy)) begin
			start <= 1'b0;
		end else begin
			in_flight = txn_q.pop_front();
			kind <= in_flight.kind;
			word <= in_flight.word;
			start <= 1'b1;
			idle_left <= pick_gap();
		end
	end

	// Monitor: record accepted steps, check each strobed result
	always @(posedge clk) begin
		step_result_t got, want;
		handed <= arst_n && start && !busy;
		if (arst_n && start && !busy && in_flight.kind)
			result_q = {result_q, in_flight.outcome};
		if (arst_n && done) begin
			got = '{exec_address, reg_written, reg_number, reg_value, mem_written,
				mem_address, mem_value, halted_flag, fault_t'(fault_code)};
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = result_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = 1'b0;
		word = '0;
		handed = 0;
		idle_left = 0;
		burst_left = 0;
		mismatches = 0;
		step_count = 0;
		in_flight.kind = 1'b0;
		build_program();
		repeat (4) @(posedge clk);
		#1 arst_n = 1'b1;
		while (txn_q.size() != 0 || start) @(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && result_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
